/* rtl/ccr_pkg.sv */
package ccr_pkg;

	localparam int COORD_W   = 32;
	localparam int SLOT_W    = 5;
	localparam int SEG_W     = 5;
	localparam int FRAC_IN_W = 16;
	localparam int CNT_W     = 6;

	localparam logic [CNT_W-1:0] CNT_RESET = 6'd23;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

endpackage

/* rtl/ccr_in_if.sv */
interface ccr_in_if;
	import ccr_pkg::*;

	logic              valid;
	logic              ready;
	func_t             func;
	logic [SLOT_W-1:0] point_slot;
	coord_t            coord_x;
	coord_t            coord_y;
	coord_t            coord_z;
	logic [SEG_W-1:0]  segment;
	logic [FRAC_IN_W-1:0] fraction;

	modport source(output valid, func, point_slot, coord_x, coord_y, coord_z, segment,
		fraction, input ready);
	modport sink(input valid, func, point_slot, coord_x, coord_y, coord_z, segment,
		fraction, output ready);

endinterface

/* rtl/ccr_out_if.sv */
interface ccr_out_if;
	import ccr_pkg::*;

	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	coord_t tan_x;
	coord_t tan_y;
	coord_t tan_z;
	logic   bad_segment;

	modport source(output valid, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, bad_segment,
		input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, bad_segment,
		output ready);

endinterface

/* rtl/closed_catmull_rom_evaluator_unit.sv */
// Evaluate beats give one result beat each, through a seven-stage pipeline
// (index wrap, store read with f^2, f^3, weights, products, sums,
// saturation) that takes one beat every cycle while the output is not stalled.
// Load beats write the point store at acceptance and give no result.
// Reset clears the stage valid bits and sets the point count to 23; the
// point store is not cleared and holds garbage until written.
module closed_catmull_rom_evaluator_unit #(
	parameter int MAX_POINTS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ccr_pkg::CNT_W-1:0] cfg_wdata,
	ccr_in_if.sink                    in_ch,
	ccr_out_if.source                 out_ch
);
	import ccr_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int XW = (CW > CNT_W) ? CW : CNT_W;
	localparam int FB = FRAC_BITS;
	localparam int WW = FB + 6;
	localparam int PW = COORD_W + WW;
	localparam int SW = PW + 2;
	localparam int EW = 3 * COORD_W;

	localparam logic signed [WW-1:0] ONE = {{(WW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic signed [WW-1:0] K2  = WW'(2);
	localparam logic signed [WW-1:0] K3  = WW'(3);
	localparam logic signed [WW-1:0] K4  = WW'(4);
	localparam logic signed [WW-1:0] K5  = WW'(5);
	localparam logic signed [WW-1:0] K8  = WW'(8);
	localparam logic signed [WW-1:0] K9  = WW'(9);
	localparam logic signed [WW-1:0] K10 = WW'(10);

	logic [CNT_W-1:0] point_count_q;
	logic [EW-1:0]    mem_a_q [MAX_POINTS];
	logic [EW-1:0]    mem_b_q [MAX_POINTS];

	// Stage valids and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7;

	logic acc_in, wr_en;
	logic [XW-1:0] n_c, seg_c, idx0_c, idx1_c, idx2_c, idx3_c;
	logic bad_c;

	logic [AW-1:0] idx_s1 [4];
	logic [FB-1:0] f_s1;
	logic          bad_s1;

	logic [EW-1:0]   rd_s2 [4];
	logic [2*FB-1:0] sq_c;
	logic [FB-1:0]   f_s2, ff_s2;
	logic            bad_s2;

	logic [EW-1:0]   rd_s3 [4];
	logic [2*FB-1:0] cu_c;
	logic [FB-1:0]   f_s3, ff_s3, fff_s3;
	logic            bad_s3;

	logic signed [WW-1:0] fe_c, ffe_c, fffe_c;
	logic signed [WW-1:0] wp_s4 [4];
	logic signed [WW-1:0] wt_s4 [4];
	logic [EW-1:0]        rd_s4 [4];
	logic                 bad_s4;

	logic signed [PW-1:0] pp_s5 [4][3];
	logic signed [PW-1:0] pt_s5 [4][3];
	logic                 bad_s5;

	logic signed [SW-1:0] sp_s6 [3];
	logic signed [SW-1:0] st_s6 [3];
	logic                 bad_s6;

	coord_t pos_s7 [3];
	coord_t tan_s7 [3];
	logic   bad_s7;

	function automatic coord_t sat_shift(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] sh;
		logic [SW-COORD_W:0]  hi;
		sh = v >>> (FB + 1);
		hi = sh[SW-1:COORD_W-1];
		if ((&hi) || !(|hi)) begin
			sat_shift = sh[COORD_W-1:0];
		end else if (sh[SW-1]) begin
			sat_shift = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat_shift = {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

	assign ld_s7 = !v_s7 || out_ch.ready;
	assign ld_s6 = !v_s6 || ld_s7;
	assign ld_s5 = !v_s5 || ld_s6;
	assign ld_s4 = !v_s4 || ld_s5;
	assign ld_s3 = !v_s3 || ld_s4;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;

	assign in_ch.ready = ld_s1;
	assign acc_in      = in_ch.valid && ld_s1;
	assign wr_en       = acc_in && (in_ch.func == FUNC_LOAD)
		&& (32'(in_ch.point_slot) < MAX_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (cfg_we) begin
				point_count_q <= cfg_wdata;
			end
			if (ld_s1) v_s1 <= acc_in && (in_ch.func == FUNC_EVAL);
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_s6) v_s6 <= v_s5;
			if (ld_s7) v_s7 <= v_s6;
		end
	end

	// Neighbor indices around the closed loop.
	always_comb begin
		if (point_count_q == '0) begin
			n_c = XW'(1);
		end else if (32'(point_count_q) > MAX_POINTS) begin
			n_c = XW'(MAX_POINTS);
		end else begin
			n_c = XW'(point_count_q);
		end
		seg_c = XW'(in_ch.segment);
		bad_c = seg_c >= n_c;
		idx1_c = seg_c;
		idx0_c = (seg_c != '0) ? seg_c - XW'(1) : n_c - XW'(1);
		idx2_c = (seg_c + XW'(1) >= n_c) ? '0 : seg_c + XW'(1);
		idx3_c = (idx2_c + XW'(1) >= n_c) ? '0 : idx2_c + XW'(1);
		if (bad_c) begin
			idx0_c = '0;
			idx1_c = '0;
			idx2_c = '0;
			idx3_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			idx_s1[0] <= AW'(idx0_c);
			idx_s1[1] <= AW'(idx1_c);
			idx_s1[2] <= AW'(idx2_c);
			idx_s1[3] <= AW'(idx3_c);
			f_s1      <= FB'(in_ch.fraction);
			bad_s1    <= bad_c;
		end
	end

	// Two identical copies of the store, each read at two addresses. A load
	// written here is seen by every evaluate accepted after it.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a_q[AW'(in_ch.point_slot)] <= {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
			mem_b_q[AW'(in_ch.point_slot)] <= {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
		end
		if (ld_s2) begin
			rd_s2[0] <= mem_a_q[idx_s1[0]];
			rd_s2[1] <= mem_a_q[idx_s1[1]];
			rd_s2[2] <= mem_b_q[idx_s1[2]];
			rd_s2[3] <= mem_b_q[idx_s1[3]];
		end
	end

	assign sq_c = f_s1 * f_s1;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			f_s2   <= f_s1;
			ff_s2  <= sq_c[2*FB-1:FB];
			bad_s2 <= bad_s1;
		end
	end

	assign cu_c = ff_s2 * f_s2;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			f_s3   <= f_s2;
			ff_s3  <= ff_s2;
			fff_s3 <= cu_c[2*FB-1:FB];
			rd_s3  <= rd_s2;
			bad_s3 <= bad_s2;
		end
	end

	assign fe_c   = signed'(WW'(f_s3));
	assign ffe_c  = signed'(WW'(ff_s3));
	assign fffe_c = signed'(WW'(fff_s3));

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			wp_s4[0] <= -fffe_c + K2 * ffe_c - fe_c;
			wp_s4[1] <= K3 * fffe_c - K5 * ffe_c + K2 * ONE;
			wp_s4[2] <= -(K3 * fffe_c) + K4 * ffe_c + fe_c;
			wp_s4[3] <= fffe_c - ffe_c;
			wt_s4[0] <= -(K3 * ffe_c) + K4 * fe_c - ONE;
			wt_s4[1] <= K9 * ffe_c - K10 * fe_c;
			wt_s4[2] <= -(K9 * ffe_c) + K8 * fe_c + ONE;
			wt_s4[3] <= K3 * ffe_c - K2 * fe_c;
			rd_s4    <= rd_s3;
			bad_s4   <= bad_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			for (int k = 0; k < 4; k++) begin
				for (int a = 0; a < 3; a++) begin
					pp_s5[k][a] <= signed'(rd_s4[k][a*COORD_W +: COORD_W]) * wp_s4[k];
					pt_s5[k][a] <= signed'(rd_s4[k][a*COORD_W +: COORD_W]) * wt_s4[k];
				end
			end
			bad_s5 <= bad_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			for (int a = 0; a < 3; a++) begin
				sp_s6[a] <= SW'(pp_s5[0][a]) + SW'(pp_s5[1][a])
					+ SW'(pp_s5[2][a]) + SW'(pp_s5[3][a]);
				st_s6[a] <= SW'(pt_s5[0][a]) + SW'(pt_s5[1][a])
					+ SW'(pt_s5[2][a]) + SW'(pt_s5[3][a]);
			end
			bad_s6 <= bad_s5;
		end
	end

	// Halve with floor rounding, then clamp to Q16.16; a bad segment reads zero.
	always_ff @(posedge clk) begin
		if (ld_s7) begin
			for (int a = 0; a < 3; a++) begin
				pos_s7[a] <= bad_s6 ? '0 : sat_shift(sp_s6[a]);
				tan_s7[a] <= bad_s6 ? '0 : sat_shift(st_s6[a]);
			end
			bad_s7 <= bad_s6;
		end
	end

	assign out_ch.valid       = v_s7;
	assign out_ch.pos_x       = pos_s7[0];
	assign out_ch.pos_y       = pos_s7[1];
	assign out_ch.pos_z       = pos_s7[2];
	assign out_ch.tan_x       = tan_s7[0];
	assign out_ch.tan_y       = tan_s7[1];
	assign out_ch.tan_z       = tan_s7[2];
	assign out_ch.bad_segment = bad_s7;

endmodule

/* tb/closed_catmull_rom_evaluator_unit_tb.sv */
`timescale 1ns / 1ps

module closed_catmull_rom_evaluator_unit_tb;
	import ccr_pkg::*;

	localparam int     STORE_DEPTH = 32;
	localparam int     FRAC_SHIFT  = 16;
	localparam longint FRAC_ONE    = 64'sd65536;
	localparam int     AXIS_X      = 0;
	localparam int     AXIS_Y      = 1;
	localparam int     AXIS_Z      = 2;
	localparam int     IDLE_LIMIT  = 2000;
	localparam int     PRINT_CAP   = 100;
	localparam coord_t C_MAX       = 32'h7FFF_FFFF;
	localparam coord_t C_MIN       = 32'h8000_0000;

	typedef struct {
		func_t                func;
		logic [SLOT_W-1:0]    slot;
		coord_t               x;
		coord_t               y;
		coord_t               z;
		logic [SEG_W-1:0]     seg;
		logic [FRAC_IN_W-1:0] frac;
	} spline_beat_t;

	typedef struct {
		coord_t px;
		coord_t py;
		coord_t pz;
		coord_t tx;
		coord_t ty;
		coord_t tz;
		logic   bad;
	} curve_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	ccr_in_if  in_ch();
	ccr_out_if out_ch();

	closed_catmull_rom_evaluator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	spline_beat_t     beat_backlog[$];
	curve_t           curve_due_q[$];
	coord_t           knots[STORE_DEPTH][3];
	logic [CNT_W-1:0] loop_count;
	int               beats_queued;
	int               beats_taken;
	int               err_count;
	int               burst_left;
	int               gap_left;
	int               idle_cycles;
	int               pat_age;
	logic [12:0]      stall_pat;
	spline_beat_t     next_beat;
	spline_beat_t     took;
	curve_t           want;
	logic [CNT_W-1:0] plan[8];

	task automatic log_mismatch(string msg);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			log_mismatch($sformatf("%s got %08h want %08h", name, got, exp_val));
	endtask

	function automatic int unsigned live_points();
		if (loop_count == 0)
			return 1;
		if (loop_count > STORE_DEPTH)
			return STORE_DEPTH;
		return loop_count;
	endfunction

	function automatic coord_t blend_axis(longint w[4], int unsigned ix[4], int axis);
		longint acc;
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += longint'(knots[ix[k]][axis]) * w[k];
		// Halve and drop the fraction in one floor shift.
		acc = acc >>> (FRAC_SHIFT + 1);
		if (acc > longint'(C_MAX))
			return C_MAX;
		if (acc < longint'(C_MIN))
			return C_MIN;
		return coord_t'(acc);
	endfunction

	function automatic curve_t predict_curve(logic [SEG_W-1:0] seg, logic [FRAC_IN_W-1:0] frac);
		curve_t      r;
		int unsigned n;
		int unsigned ix[4];
		longint      f;
		longint      ff;
		longint      fff;
		longint      wp[4];
		longint      wt[4];
		r = '{default: '0};
		n = live_points();
		if (seg >= n) begin
			r.bad = 1'b1;
			return r;
		end
		ix[1] = seg;
		ix[0] = (seg == 0) ? n - 1 : seg - 1;
		ix[2] = (seg + 1 >= n) ? 0 : seg + 1;
		ix[3] = (ix[2] + 1 >= n) ? 0 : ix[2] + 1;
		f   = longint'(frac);
		ff  = (f * f) >>> FRAC_SHIFT;
		fff = (ff * f) >>> FRAC_SHIFT;
		wp[0] = -fff + 2 * ff - f;
		wp[1] = 3 * fff - 5 * ff + 2 * FRAC_ONE;
		wp[2] = -3 * fff + 4 * ff + f;
		wp[3] = fff - ff;
		wt[0] = -3 * ff + 4 * f - FRAC_ONE;
		wt[1] = 9 * ff - 10 * f;
		wt[2] = -9 * ff + 8 * f + FRAC_ONE;
		wt[3] = 3 * ff - 2 * f;
		r.px = blend_axis(wp, ix, AXIS_X);
		r.py = blend_axis(wp, ix, AXIS_Y);
		r.pz = blend_axis(wp, ix, AXIS_Z);
		r.tx = blend_axis(wt, ix, AXIS_X);
		r.ty = blend_axis(wt, ix, AXIS_Y);
		r.tz = blend_axis(wt, ix, AXIS_Z);
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return C_MAX;
			1: return C_MIN;
			2: return coord_t'($urandom_range(0, 3)) - 32'sd1;
			3: return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			default: return coord_t'($urandom());
		endcase
	endfunction

	task automatic push_load(int slot, coord_t x, coord_t y, coord_t z);
		spline_beat_t b;
		b.func  = FUNC_LOAD;
		b.slot  = SLOT_W'(slot);
		b.x     = x;
		b.y     = y;
		b.z     = z;
		b.seg   = SEG_W'($urandom());
		b.frac  = FRAC_IN_W'($urandom());
		beat_backlog.push_back(b);
		beats_queued++;
	endtask

	task automatic push_eval(int seg, int frac);
		spline_beat_t b;
		b.func  = FUNC_EVAL;
		b.slot  = SLOT_W'($urandom());
		b.x     = coord_t'($urandom());
		b.y     = coord_t'($urandom());
		b.z     = coord_t'($urandom());
		b.seg   = SEG_W'(seg);
		b.frac  = FRAC_IN_W'(frac);
		beat_backlog.push_back(b);
		beats_queued++;
	endtask

	// Loads give no result, so settle waits for every queued beat and result, then lets the pipeline drain.
	task automatic settle();
		while (beats_taken != beats_queued || curve_due_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		loop_count = v;
	endtask

	task automatic run_random_phase(int count);
		int frac;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 2) begin
				push_load($urandom_range(0, STORE_DEPTH - 1), rand_coord(), rand_coord(),
					rand_coord());
			end else begin
				case ($urandom_range(0, 9))
					0: frac = 0;
					1: frac = 16'hFFFF;
					default: frac = $urandom_range(0, 16'hFFFF);
				endcase
				if ($urandom_range(0, 6) == 0)
					push_eval($urandom_range(0, 31), frac);
				else
					push_eval($urandom_range(0, live_points() - 1), frac);
			end
		end
	endtask

	// Driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				took.func = in_ch.func;
				took.slot = in_ch.point_slot;
				took.x    = in_ch.coord_x;
				took.y    = in_ch.coord_y;
				took.z    = in_ch.coord_z;
				took.seg  = in_ch.segment;
				took.frac = in_ch.fraction;
				if (took.func == FUNC_LOAD) begin
					knots[took.slot][AXIS_X] = took.x;
					knots[took.slot][AXIS_Y] = took.y;
					knots[took.slot][AXIS_Z] = took.z;
				end else begin
					curve_due_q.push_back(predict_curve(took.seg, took.frac));
				end
				beats_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0 || beat_backlog.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_ch.valid <= 1'b0;
				end else begin
					next_beat = beat_backlog.pop_front();
					in_ch.func       <= next_beat.func;
					in_ch.point_slot <= next_beat.slot;
					in_ch.coord_x    <= next_beat.x;
					in_ch.coord_y    <= next_beat.y;
					in_ch.coord_z    <= next_beat.z;
					in_ch.segment    <= next_beat.seg;
					in_ch.fraction   <= next_beat.frac;
					in_ch.valid      <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// Monitor: the ready pattern rotates and is replaced every so often,
	// sometimes by all ones so that long stretches run without a stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_pat = '1;
			pat_age   = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (curve_due_q.size() == 0) begin
					log_mismatch("result beat with nothing expected");
				end else begin
					want = curve_due_q.pop_front();
					check_field("pos_x", out_ch.pos_x, want.px);
					check_field("pos_y", out_ch.pos_y, want.py);
					check_field("pos_z", out_ch.pos_z, want.pz);
					check_field("tan_x", out_ch.tan_x, want.tx);
					check_field("tan_y", out_ch.tan_y, want.ty);
					check_field("tan_z", out_ch.tan_z, want.tz);
					check_field("bad_segment", 32'(out_ch.bad_segment), 32'(want.bad));
				end
			end
			pat_age++;
			if (pat_age >= 80) begin
				pat_age   = 0;
				stall_pat = ($urandom_range(0, 3) == 0) ? '1 : (13'($urandom()) | 13'h1);
			end else begin
				stall_pat = {stall_pat[11:0], stall_pat[12]};
			end
			out_ch.ready <= stall_pat[0];
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] watchdog: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		in_ch.valid      = 1'b0;
		in_ch.func       = FUNC_LOAD;
		in_ch.point_slot = '0;
		in_ch.coord_x    = '0;
		in_ch.coord_y    = '0;
		in_ch.coord_z    = '0;
		in_ch.segment    = '0;
		in_ch.fraction   = '0;
		out_ch.ready     = 1'b0;
		loop_count       = CNT_RESET;
		beats_queued     = 0;
		beats_taken      = 0;
		err_count        = 0;
		idle_cycles      = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset count of 23. Alternating extremes on x drive the tangent into
		// saturation at the segment midpoint.
		push_load(0, C_MAX, C_MAX, 32'sh0001_0000);
		push_load(1, C_MIN, C_MAX, -32'sd1);
		push_load(2, C_MAX, C_MAX, 32'sh0002_8000);
		push_load(3, C_MIN, C_MAX, 32'sd0);
		push_eval(1, 0);
		push_eval(1, 16'hFFFF);
		push_eval(1, 16'h8000);
		push_eval(1, 1);
		push_eval(23, 16'h1234);
		push_eval(31, 16'hFFFF);
		settle();

		// Four-point loop: segments 0, 2 and 3 have neighbors that wrap.
		write_count(6'd4);
		push_eval(0, 16'h8000);
		push_eval(3, 16'hFFFF);
		push_eval(2, 16'h4000);
		push_eval(4, 0);
		push_eval(31, 16'h8000);
		settle();

		// Fill the whole store before anything can read past slot 3.
		write_count(6'd32);
		for (int s = 0; s < STORE_DEPTH; s++)
			push_load(s, rand_coord(), rand_coord(), rand_coord());

		// A count of zero acts as one point, and counts above the store size
		// act as the store size.
		plan = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd40, 6'd17, 6'd5, 6'd4};
		plan[6] = CNT_W'($urandom_range(5, 31));
		foreach (plan[p]) begin
			if (p != 0) begin
				settle();
				write_count(plan[p]);
			end
			run_random_phase(65);
		end

		settle();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
